// ----- rtl/core/lcd4_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4_pkg: shared types and constants for the 4-bit character LCD core
// Request codes, init sequence tables and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lcd4_pkg;

	// request action codes
	localparam logic [1:0] ACT_POWER_ON = 2'd0;
	localparam logic [1:0] ACT_COMMAND  = 2'd1;
	localparam logic [1:0] ACT_DATA     = 2'd2;
	localparam logic [1:0] ACT_CURSOR   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_CLOCKS_PER_MS   = 2'd0;
	localparam logic [1:0] CFG_ENABLE_PHASE_MS = 2'd1;

	localparam logic [19:0] CLOCKS_PER_MS_RST   = 20'd100000;
	localparam logic [3:0]  ENABLE_PHASE_MS_RST = 4'd1;

	localparam logic [7:0] CURSOR_BASE = 8'h80;
	localparam logic [7:0] ROW_STRIDE  = 8'h40;

	// index of the final strobe of the power-on sequence
	localparam logic [3:0] INIT_LAST = 4'd13;

	typedef struct packed {
		logic load_req;     // latch request, restart at first strobe
		logic start_wait;   // load timer with pre-strobe wait
		logic start_phase;  // load timer with the three enable phases
		logic emit;         // push strobe to output register, advance
	} lcd4_cmd_t;

	typedef struct packed {
		logic timer_done;
		logic strobe_last;
		logic out_free;
	} lcd4_status_t;

	function automatic logic [3:0] init_nibble(input logic [3:0] step);
		logic [3:0] nib;
		case (step)
			4'd0, 4'd1, 4'd2: nib = 4'h3;
			4'd3, 4'd4:       nib = 4'h2;
			4'd5, 4'd7:       nib = 4'h8;
			4'd9:             nib = 4'h1;
			4'd11:            nib = 4'h6;
			4'd13:            nib = 4'hC;
			default:          nib = 4'h0;
		endcase
		return nib;
	endfunction

	function automatic logic [3:0] init_wait(input logic [3:0] step);
		logic [3:0] w;
		case (step)
			4'd0:    w = 4'd15;
			4'd1:    w = 4'd5;
			4'd2:    w = 4'd1;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/char_lcd_4bit_interface_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_core: HD44780-style 4-bit LCD request engine
// Turns power-on / command / data / cursor requests into timed enable strobes.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tuser: action; tdata: byte_value, row, column
// m_axis    out        tuser: RS; tdata: nibble, extra_wait_ms; tlast: last
// cfg       in         cfg_index 0 clocks_per_ms, 1 enable_phase_ms
//
// Each strobe takes extra_wait_ms + 3*enable_phase_ms milliseconds of the
// ms timer (each millisecond set by clocks_per_ms) plus the sequencer states.
// A byte request is two strobes, power-on is fourteen (21 ms of extra waits).
// One request is worked at a time; the next is taken once its last strobe is
// in the output register. A stalled result holds the sequencer in EMIT.
// Reset: clocks_per_ms from CLOCKS_PER_MS_RST, 1 ms enable phase, output empty.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] byte_value, [8] row, [14:9] column
	input  wire  [1:0]  s_axis_tuser,   // [1:0] action
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [3:0] nibble, [7:4] extra_wait_ms
	output logic        m_axis_tuser,   // [0] reg_select
	output logic        m_axis_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [19:0] cfg_data
);

	lcd4_pkg::lcd4_cmd_t    cmd;
	lcd4_pkg::lcd4_status_t status;

	assign cfg_ready = 1'b1;

	lcd4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lcd4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req_data  (s_axis_tdata),
		.req_user  (s_axis_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ----- rtl/core/lcd4_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4_ctrl: strobe sequencing state machine
// Steps each request through wait, enable phases and result hand-off.
// ----------------------------------------------------------------------------
module lcd4_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_ready,
	input  lcd4_pkg::lcd4_status_t status,
	output lcd4_pkg::lcd4_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_PHASE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_START;
				end
			end
			ST_START: begin
				cmd.start_wait = 1'b1;
				state_d        = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.timer_done) begin
					cmd.start_phase = 1'b1;
					state_d         = ST_PHASE;
				end
			end
			ST_PHASE: begin
				if (status.timer_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.strobe_last ? ST_IDLE : ST_START;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

// ----- rtl/core/lcd4_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd4_dp: request registers, millisecond timer and output register
// Holds the current request, picks each strobe's fields, times the delays.
// ----------------------------------------------------------------------------
module lcd4_dp (
	input  wire                    clk,
	input  wire                    arst_n,
	input  lcd4_pkg::lcd4_cmd_t    cmd,
	output lcd4_pkg::lcd4_status_t status,
	input  wire  [15:0]            req_data,
	input  wire  [1:0]             req_user,
	input  wire                    cfg_valid,
	input  wire  [1:0]             cfg_index,
	input  wire  [19:0]            cfg_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [7:0]             out_data,
	output logic                   out_user,
	output logic                   out_last
);

	logic [19:0] clocks_per_ms_q;
	logic [3:0]  phase_ms_q;

	logic [1:0]  action_q;
	logic [7:0]  byte_q;
	logic [3:0]  step_q;

	logic [19:0] clk_cnt_q;
	logic [5:0]  ms_left_q;

	logic        m_valid_q;
	logic        out_rs_q;
	logic [3:0]  out_nib_q;
	logic [3:0]  out_wait_q;
	logic        out_last_q;

	logic [7:0]  req_byte;
	logic [7:0]  row_offset;
	logic        cur_rs;
	logic [3:0]  cur_nib;
	logic [3:0]  cur_wait;
	logic        cur_last;
	logic [5:0]  phase_total;
	logic        ms_tick;
	logic        is_init;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clocks_per_ms_q <= lcd4_pkg::CLOCKS_PER_MS_RST;
			phase_ms_q      <= lcd4_pkg::ENABLE_PHASE_MS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == lcd4_pkg::CFG_CLOCKS_PER_MS) clocks_per_ms_q <= cfg_data;
			if (cfg_index == lcd4_pkg::CFG_ENABLE_PHASE_MS) phase_ms_q <= cfg_data[3:0];
		end
	end

	// cursor address: base + row stride (row 1 only) + column, column not range checked
	assign row_offset = req_data[8] ? lcd4_pkg::ROW_STRIDE : 8'd0;
	assign req_byte   = (req_user == lcd4_pkg::ACT_CURSOR)
		? lcd4_pkg::CURSOR_BASE + row_offset + {2'b00, req_data[14:9]}
		: req_data[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			action_q <= lcd4_pkg::ACT_POWER_ON;
		end else if (cmd.load_req) begin
			step_q   <= '0;
			action_q <= req_user;
		end else if (cmd.emit && !cur_last) begin
			step_q   <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) byte_q <= req_byte;
	end

	// strobe field selection
	assign is_init = (action_q == lcd4_pkg::ACT_POWER_ON);

	always_comb begin
		cur_rs = (action_q == lcd4_pkg::ACT_DATA);
		if (is_init) begin
			cur_nib  = lcd4_pkg::init_nibble(step_q);
			cur_wait = lcd4_pkg::init_wait(step_q);
			cur_last = (step_q == lcd4_pkg::INIT_LAST);
		end else begin
			cur_nib  = step_q[0] ? byte_q[3:0] : byte_q[7:4];
			cur_wait = 4'd0;
			cur_last = step_q[0];
		end
	end

	// millisecond timer
	assign phase_total = {2'b00, phase_ms_q} + {1'b0, phase_ms_q, 1'b0};
	assign ms_tick     = (clk_cnt_q == clocks_per_ms_q - 20'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_cnt_q <= '0;
			ms_left_q <= '0;
		end else if (cmd.start_wait) begin
			clk_cnt_q <= '0;
			ms_left_q <= {2'b00, cur_wait};
		end else if (cmd.start_phase) begin
			clk_cnt_q <= '0;
			ms_left_q <= phase_total;
		end else if (ms_left_q != 6'd0) begin
			if (ms_tick) begin
				clk_cnt_q <= '0;
				ms_left_q <= ms_left_q - 6'd1;
			end else begin
				clk_cnt_q <= clk_cnt_q + 20'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_rs_q   <= cur_rs;
			out_nib_q  <= cur_nib;
			out_wait_q <= cur_wait;
			out_last_q <= cur_last;
		end
	end

	assign status.timer_done  = (ms_left_q == 6'd0);
	assign status.strobe_last = cur_last;
	assign status.out_free    = !m_valid_q || out_ready;

	assign out_valid = m_valid_q;
	assign out_data  = {out_wait_q, out_nib_q};
	assign out_user  = out_rs_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= lcd4_pkg::INIT_LAST)
		else $error("strobe index past end of power-on sequence");

	a_byte_two_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		!is_init |-> step_q <= 4'd1)
		else $error("byte request beyond two strobes");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_valid_q || out_ready))
		else $error("result overwritten before taken");

	a_timer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ms_left_q <= 6'd45)
		else $error("ms timer out of range");

	a_emit_after_timer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ms_left_q == 6'd0)
		else $error("strobe issued before phases elapsed");
`endif

endmodule
`default_nettype wire
